// ===== rtl/spi_mrt_pkg.sv =====
// Shared types and constants for the SPI master register transfer unit.
// Used by the channel interfaces, the sequencer, the transmit buffer and the top level.
// No dependencies.
package spi_mrt_pkg;

    localparam int PTR_W    = 5;   // load index and send pointer width
    localparam int CNT_W    = 6;   // byte count, remaining counts, receive pointer
    localparam int TX_SLOTS = 32;  // entries a 5-bit index can reach

    localparam logic [7:0] DUMMY_BYTE = 8'hFF;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_START_RD = 2'd1;
    localparam logic [1:0] OP_START_WR = 2'd2;
    localparam logic [1:0] OP_RX       = 2'd3;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ADDR  = 2'd1;
    localparam logic [1:0] PH_WRITE = 2'd2;
    localparam logic [1:0] PH_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [7:0]       addr_byte;
        logic [CNT_W-1:0] byte_count;
        logic [PTR_W-1:0] load_index;
        logic [7:0]       load_data;
        logic [7:0]       rx_byte;
    } t_in_item;

    typedef struct packed {
        logic             send_valid;
        logic [7:0]       send_byte;
        logic             store_valid;
        logic [CNT_W-1:0] store_index;
        logic [7:0]       store_data;
        logic             done_res;
        logic [1:0]       phase;
        logic             rejected;
    } t_out_item;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] idx;
        logic [7:0]       data;
    } t_tx_wr;

endpackage

// ===== rtl/spi_mrt_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
// Depends on spi_mrt_pkg for the payload types.
interface spi_mrt_in_if;
    import spi_mrt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spi_mrt_out_if;
    import spi_mrt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/spi_mrt_txbuf.sv =====
// Transmit byte buffer: one write port for load items, one read port at the send pointer.
// Depends on spi_mrt_pkg.
module spi_mrt_txbuf #(
    parameter int BUF_LEN = 32
) (
    input  logic                           i_clk,
    input  spi_mrt_pkg::t_tx_wr            i_wr,
    input  logic [spi_mrt_pkg::PTR_W-1:0]  i_rd_ptr,
    output logic [7:0]                     o_rd_data
);
    import spi_mrt_pkg::*;

    localparam int DEPTH = (BUF_LEN < TX_SLOTS) ? BUF_LEN : TX_SLOTS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] r_store [DEPTH];

    // Writes are already range checked by the sequencer.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.idx[IDX_W-1:0]] <= i_wr.data;
        end
    end

    // An out-of-range pointer is masked by the sequencer.
    assign o_rd_data = r_store[i_rd_ptr[IDX_W-1:0]];

endmodule

// ===== rtl/spi_mrt_seq.sv =====
// Transaction sequencer: phase, remaining counts and pointers, and the result of one item.
// Depends on spi_mrt_pkg; reads the transmit buffer through spi_mrt_txbuf.
module spi_mrt_seq #(
    parameter int BUF_LEN = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  spi_mrt_pkg::t_in_item          i_item,
    input  logic [7:0]                     i_tx_data,
    output logic [spi_mrt_pkg::PTR_W-1:0]  o_tx_rd_ptr,
    output spi_mrt_pkg::t_tx_wr            o_tx_wr,
    output spi_mrt_pkg::t_out_item         o_res
);
    import spi_mrt_pkg::*;

    localparam logic [7:0] BUF_LIM = 8'(BUF_LEN);

    logic [1:0]       r_phase,     n_phase;
    logic [CNT_W-1:0] r_write_rem, n_write_rem;
    logic [CNT_W-1:0] r_read_rem,  n_read_rem;
    logic [PTR_W-1:0] r_send_ptr,  n_send_ptr;
    logic [CNT_W-1:0] r_recv_ptr,  n_recv_ptr;

    logic [CNT_W-1:0] cnt_sat;
    logic [CNT_W-1:0] read_dec;
    logic [7:0]       data_byte;
    t_out_item        res;

    assign o_tx_rd_ptr = r_send_ptr;

    // Data byte at the send pointer; positions past the buffer send zero.
    assign data_byte = ({3'b000, r_send_ptr} < BUF_LIM) ? i_tx_data : 8'h00;

    assign cnt_sat = ({2'b00, i_item.byte_count} > BUF_LIM) ? BUF_LIM[CNT_W-1:0]
                                                             : i_item.byte_count;
    assign read_dec = (r_read_rem != '0) ? (r_read_rem - 1'b1) : r_read_rem;

    always_comb begin
        o_tx_wr.en   = (i_item.opcode == OP_LOAD) && ({3'b000, i_item.load_index} < BUF_LIM);
        o_tx_wr.idx  = i_item.load_index;
        o_tx_wr.data = i_item.load_data;
    end

    always_comb begin
        n_phase     = r_phase;
        n_write_rem = r_write_rem;
        n_read_rem  = r_read_rem;
        n_send_ptr  = r_send_ptr;
        n_recv_ptr  = r_recv_ptr;
        res         = '0;

        case (i_item.opcode)
            OP_START_RD, OP_START_WR: begin
                if (r_phase != PH_IDLE) begin
                    res.rejected = 1'b1;
                end else begin
                    n_read_rem     = (i_item.opcode == OP_START_RD) ? cnt_sat : '0;
                    n_write_rem    = (i_item.opcode == OP_START_WR) ? cnt_sat : '0;
                    n_send_ptr     = '0;
                    n_recv_ptr     = '0;
                    n_phase        = PH_ADDR;
                    res.send_valid = 1'b1;
                    res.send_byte  = i_item.addr_byte;
                end
            end
            OP_RX: begin
                if (r_phase != PH_IDLE) begin
                    res.store_valid = 1'b1;
                    res.store_index = r_recv_ptr;
                    res.store_data  = i_item.rx_byte;
                    n_recv_ptr      = r_recv_ptr + 1'b1;
                    case (r_phase)
                        PH_ADDR, PH_WRITE: begin
                            if (r_phase == PH_ADDR && r_read_rem != '0) begin
                                n_phase        = PH_READ;
                                res.send_valid = 1'b1;
                                res.send_byte  = DUMMY_BYTE;
                            end else if (r_write_rem != '0) begin
                                n_phase        = PH_WRITE;
                                res.send_valid = 1'b1;
                                res.send_byte  = data_byte;
                                n_send_ptr     = r_send_ptr + 1'b1;
                                n_write_rem    = r_write_rem - 1'b1;
                            end else begin
                                n_phase      = PH_IDLE;
                                res.done_res = 1'b1;
                            end
                        end
                        default: begin
                            n_read_rem = read_dec;
                            if (read_dec == '0) begin
                                n_phase      = PH_IDLE;
                                res.done_res = 1'b1;
                            end else begin
                                res.send_valid = 1'b1;
                                res.send_byte  = DUMMY_BYTE;
                            end
                        end
                    endcase
                end
            end
            default: begin
                // Load items only touch the transmit buffer.
            end
        endcase

        res.phase = n_phase;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_write_rem <= '0;
            r_read_rem  <= '0;
            r_send_ptr  <= '0;
            r_recv_ptr  <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_write_rem <= n_write_rem;
            r_read_rem  <= n_read_rem;
            r_send_ptr  <= n_send_ptr;
            r_recv_ptr  <= n_recv_ptr;
        end
    end

    a_idle_counts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_read_rem == '0 && r_write_rem == '0))
        else $error("idle phase with a nonzero remaining count");

    a_write_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WRITE) |-> (r_read_rem == '0))
        else $error("write phase with a pending read count");

    a_start_enters_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_IDLE &&
         (i_item.opcode == OP_START_RD || i_item.opcode == OP_START_WR))
        |=> (r_phase == PH_ADDR))
        else $error("start while idle did not enter the address phase");

endmodule

// ===== rtl/spi_master_register_transfer_unit.sv =====
// Top level of the SPI master register transfer unit: input register, sequencer, result register.
// Depends on spi_mrt_pkg, spi_mrt_if, spi_mrt_txbuf and spi_mrt_seq.
//
// The unit has one input channel (i_in) and one result channel (o_out), both valid/ready.
// A transfer happens at a rising edge where valid and ready are both high. Every input item
// gives exactly one result item, in order. Load items fill the transmit buffer; start items
// send the register address and open a read or a write; received-byte items store the byte
// and tell which byte, if any, the SPI shifter sends next, and when chip select releases.
//
// An accepted item sits in the input register until the result register is free; then the
// sequencer updates its state and writes the result register at the same edge. The sustained
// rate is one item per cycle while the receiver takes results, as the phase update is short.
//
// When the receiver stalls, the result register holds its item and the input register
// still takes one more item; after that i_in.ready falls until o_out.ready returns.
// Synchronous active-low reset empties both registers and puts the sequencer in the idle
// phase with all counts and pointers at zero. The transmit buffer is not cleared: entries
// must be loaded before a write sends them.
module spi_master_register_transfer_unit #(
    parameter int BUF_LEN = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spi_mrt_in_if.sink           i_in,
    spi_mrt_out_if.source        o_out
);
    import spi_mrt_pkg::*;

    logic             r_s1_valid;
    t_in_item         r_s1;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             out_take;
    logic             s1_adv;
    t_out_item        seq_res;
    t_tx_wr           tx_wr;
    logic [PTR_W-1:0] tx_rd_ptr;
    logic [7:0]       tx_rd_data;

    // The result register frees up when it is empty or its item is being taken.
    assign out_take = !r_out_valid || o_out.ready;
    // The held item is processed exactly in the cycle it moves into the result register.
    assign s1_adv   = r_s1_valid && out_take;
    assign i_in.ready = !r_s1_valid || out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1 <= i_in.data;
        end
    end

    spi_mrt_seq #(
        .BUF_LEN (BUF_LEN)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (s1_adv),
        .i_item      (r_s1),
        .i_tx_data   (tx_rd_data),
        .o_tx_rd_ptr (tx_rd_ptr),
        .o_tx_wr     (tx_wr),
        .o_res       (seq_res)
    );

    // Only processed load items may write the buffer.
    t_tx_wr tx_wr_gated;
    always_comb begin
        tx_wr_gated    = tx_wr;
        tx_wr_gated.en = tx_wr.en && s1_adv;
    end

    spi_mrt_txbuf #(
        .BUF_LEN (BUF_LEN)
    ) u_txbuf (
        .i_clk     (i_clk),
        .i_wr      (tx_wr_gated),
        .i_rd_ptr  (tx_rd_ptr),
        .o_rd_data (tx_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= seq_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_done_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> (r_out.phase == PH_IDLE))
        else $error("done reported while the phase is not idle");

    a_reject_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.rejected) |-> (!r_out.send_valid && !r_out.store_valid))
        else $error("rejected start also sent or stored a byte");

endmodule
